// File: rtl/core/fnss_pkg.sv
package fnss_pkg;

    localparam int DATA_W = 16;
    localparam int SUM_W  = 18;
    localparam int CFG_W  = 11;

    typedef struct packed {
        logic [DATA_W-1:0] element_value;
        logic              drain;
    } in_item_t;

    typedef struct packed {
        logic [SUM_W-1:0] neighbor_sum;
        logic             last_of_matrix;
    } out_item_t;

    typedef struct packed {
        logic up_ok;
        logic down_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } pos_flags_t;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic              emit;
        pos_flags_t        pos;
    } cmd_t;

endpackage

// File: rtl/core/fnss_ram.sv
module fnss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read-first on a shared address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/fnss_fifo.sv
module fnss_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_valid,
    output logic                       wr_ready,
    input  logic [WIDTH-1:0]           wr_data,
    output logic                       rd_valid,
    input  logic                       rd_ready,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign level    = cnt_reg;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/fnss_front.sv
module fnss_front #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fnss_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          src_valid,
    output logic                          src_ready,
    input  fnss_pkg::in_item_t            src_item,
    output logic                          q_valid,
    input  logic                          q_ready,
    output fnss_pkg::cmd_t                q_cmd,
    output logic [$clog2(MAX_SIZE)-1:0]   s_last
);

    import fnss_pkg::*;

    localparam int COL_W = $clog2(MAX_SIZE);
    localparam int S_W   = $clog2(MAX_SIZE + 2);
    localparam int S_RST = (8 > MAX_SIZE) ? MAX_SIZE : 8;

    logic [S_W-1:0]   s_p1_reg, s_p1_next;
    logic [COL_W-1:0] s_last_reg, s_last_next;
    logic             s_one_reg, s_one_next;
    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [COL_W-1:0] in_row_reg, in_row_next;
    logic             full_reg, full_next;
    logic [S_W-1:0]   lead_reg, lead_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [COL_W-1:0] out_row_reg, out_row_next;

    logic [S_W-1:0] s_sat;
    logic           accept, is_drain, push, emit, out_last;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            s_sat = S_W'(1);
        end
        else if (32'(cfg_data) > 32'(MAX_SIZE))
        begin
            s_sat = S_W'(MAX_SIZE);
        end
        else
        begin
            s_sat = S_W'(cfg_data);
        end
    end

    assign accept   = src_valid && src_ready;
    assign is_drain = src_item.drain;
    // data only until the matrix is full, drains only after
    assign push     = is_drain ? full_reg : !full_reg;
    assign emit     = push && ((lead_reg == s_p1_reg) || (s_one_reg && is_drain));
    assign out_last = (out_row_reg == s_last_reg) && (out_col_reg == s_last_reg);

    assign src_ready = q_ready;
    assign q_valid   = src_valid && push;
    assign s_last    = s_last_reg;

    always_comb
    begin
        q_cmd.x            = src_item.element_value;
        q_cmd.emit         = emit;
        q_cmd.pos.up_ok    = out_row_reg != '0;
        q_cmd.pos.down_ok  = out_row_reg != s_last_reg;
        q_cmd.pos.left_ok  = out_col_reg != '0;
        q_cmd.pos.right_ok = out_col_reg != s_last_reg;
        q_cmd.pos.last     = out_last;
    end

    always_comb
    begin
        s_p1_next    = s_p1_reg;
        s_last_next  = s_last_reg;
        s_one_next   = s_one_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        full_next    = full_reg;
        lead_next    = lead_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            s_p1_next    = s_sat + 1'b1;
            s_last_next  = COL_W'(s_sat - 1'b1);
            s_one_next   = s_sat == S_W'(1);
            in_col_next  = '0;
            in_row_next  = '0;
            full_next    = 1'b0;
            lead_next    = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept && push)
        begin
            if (!is_drain)
            begin
                if (in_col_reg == s_last_reg)
                begin
                    in_col_next = '0;
                    if (in_row_reg == s_last_reg)
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (lead_reg != s_p1_reg)
            begin
                lead_next = lead_reg + 1'b1;
            end
            if (emit)
            begin
                if (out_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    full_next    = 1'b0;
                    lead_next    = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_reg == s_last_reg)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_p1_reg    <= S_W'(S_RST + 1);
            s_last_reg  <= COL_W'(S_RST - 1);
            s_one_reg   <= S_RST == 1;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            full_reg    <= 1'b0;
            lead_reg    <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            s_p1_reg    <= s_p1_next;
            s_last_reg  <= s_last_next;
            s_one_reg   <= s_one_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            full_reg    <= full_next;
            lead_reg    <= lead_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

// File: rtl/core/fnss_back.sv
module fnss_back #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [$clog2(MAX_SIZE)-1:0] s_last,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  fnss_pkg::cmd_t              q_cmd,
    output logic                        res_valid,
    input  logic                        res_ready,
    output fnss_pkg::out_item_t         res_item
);

    import fnss_pkg::*;

    localparam int COL_W     = $clog2(MAX_SIZE);
    localparam int OUT_DEPTH = 4;
    localparam int LVL_W     = $clog2(OUT_DEPTH + 1);

    logic [COL_W-1:0]  col_reg, col_next;

    logic              b_valid_reg;
    logic [DATA_W-1:0] b_x_reg;
    logic              b_emit_reg;
    pos_flags_t        b_pos_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic [DATA_W-1:0] prev_x_reg, h1_reg, h2_reg;

    logic              c_valid_reg;
    logic              c_emit_reg;
    pos_flags_t        c_pos_reg;
    logic [DATA_W-1:0] c_down_reg, c_right_reg, c_left_reg, up_prev_reg;

    logic [DATA_W-1:0] lb1_rd, lb2_rd;
    logic [LVL_W-1:0]  out_level;
    logic              room, pop, out_wr;
    out_item_t         out_wr_item;

    // credit check: everything in flight must fit in the output queue
    assign room = (out_level + LVL_W'(b_valid_reg && b_emit_reg)
                   + LVL_W'(c_valid_reg && c_emit_reg)) < LVL_W'(OUT_DEPTH);
    assign q_ready = room;
    assign pop     = q_valid && room;

    always_comb
    begin
        col_next = col_reg;
        if (cfg_we)
        begin
            col_next = '0;
        end
        else if (pop)
        begin
            if ((q_cmd.emit && q_cmd.pos.last) || (col_reg == s_last))
            begin
                col_next = '0;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            b_valid_reg <= pop;
            c_valid_reg <= b_valid_reg;
        end
    end

    // row above the newest item
    fnss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SIZE)
    ) u_lb1 (
        .clk     (clk),
        .wr_en   (pop),
        .wr_addr (col_reg),
        .wr_data (q_cmd.x),
        .rd_en   (pop),
        .rd_addr (col_reg),
        .rd_data (lb1_rd)
    );

    // two rows above the newest item
    fnss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SIZE)
    ) u_lb2 (
        .clk     (clk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_col_reg),
        .wr_data (lb1_rd),
        .rd_en   (b_valid_reg),
        .rd_addr (b_col_reg),
        .rd_data (lb2_rd)
    );

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_x_reg    <= q_cmd.x;
            b_emit_reg <= q_cmd.emit;
            b_pos_reg  <= q_cmd.pos;
            b_col_reg  <= col_reg;
        end
        if (b_valid_reg)
        begin
            prev_x_reg  <= b_x_reg;
            h1_reg      <= lb1_rd;
            h2_reg      <= h1_reg;
            c_emit_reg  <= b_emit_reg;
            c_pos_reg   <= b_pos_reg;
            c_down_reg  <= prev_x_reg;
            c_right_reg <= lb1_rd;
            c_left_reg  <= h2_reg;
        end
        if (c_valid_reg)
        begin
            up_prev_reg <= lb2_rd;
        end
    end

    always_comb
    begin
        out_wr_item.neighbor_sum =
              (c_pos_reg.up_ok    ? SUM_W'(up_prev_reg) : '0)
            + (c_pos_reg.down_ok  ? SUM_W'(c_down_reg)  : '0)
            + (c_pos_reg.left_ok  ? SUM_W'(c_left_reg)  : '0)
            + (c_pos_reg.right_ok ? SUM_W'(c_right_reg) : '0);
        out_wr_item.last_of_matrix = c_pos_reg.last;
    end

    assign out_wr = c_valid_reg && c_emit_reg;

    fnss_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (out_wr),
        .wr_ready (),
        .wr_data  (out_wr_item),
        .rd_valid (res_valid),
        .rd_ready (res_ready),
        .rd_data  (res_item),
        .level    (out_level)
    );

endmodule

// File: rtl/core/four_neighbor_sum_stencil.sv
// Four-neighbour sum over a square matrix streamed in raster order.
// src channel: one item per element (drain = 0) and, once the whole matrix is
// in, one drain item (drain = 1) per remaining result; early drains and
// surplus elements are swallowed without a result.
// res channel: neighbour sum of each position in raster order, with
// last_of_matrix on the bottom-right one, after which a new matrix starts.
// cfg channel: writes matrix_size (0 reads as 1, above MAX_SIZE saturates)
// and restarts the matrix; always ready; it must be written only while idle,
// which the block does not enforce. Throughput: one item per cycle unless
// res stalls, set by the two line buffer RAMs of MAX_SIZE words, each taking
// one read and one write per cycle. A neighbourhood's last item (element
// p+S+1, or a drain near the end) yields a result via the command queue,
// the b and c registers and the result queue. A stalled receiver fills the
// 4-item result queue; the back end then stops taking from the 4-item
// command queue, and src_ready falls once it is full. Reset: size 8, counters
// cleared; line buffers are not cleared since border positions mask them.
module four_neighbor_sum_stencil #(
    parameter int MAX_SIZE = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fnss_pkg::CFG_W-1:0] cfg_data,
    input  logic                       src_valid,
    output logic                       src_ready,
    input  fnss_pkg::in_item_t         src_item,
    output logic                       res_valid,
    input  logic                       res_ready,
    output fnss_pkg::out_item_t        res_item
);

    import fnss_pkg::*;

    localparam int COL_W = $clog2(MAX_SIZE);
    localparam int Q_DEPTH = 4;

    logic                 cfg_we;
    logic                 fq_valid, fq_ready;
    cmd_t                 fq_cmd;
    logic                 bq_valid, bq_ready;
    cmd_t                 bq_cmd;
    logic [COL_W-1:0]     s_last;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    fnss_front #(
        .MAX_SIZE (MAX_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_cmd     (fq_cmd),
        .s_last    (s_last)
    );

    fnss_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_cmd),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_cmd),
        .level    ()
    );

    fnss_back #(
        .MAX_SIZE (MAX_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .s_last    (s_last),
        .q_valid   (bq_valid),
        .q_ready   (bq_ready),
        .q_cmd     (bq_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

endmodule

// File: bench/tb.sv
module tb;

    import fnss_pkg::*;

    localparam int MAX_SIDE    = 1024;
    localparam int WIN_LEN     = 2 * MAX_SIDE + 2;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 2000;

    localparam logic ELEM  = 1'b0;
    localparam logic DRAIN = 1'b1;

    typedef enum logic [0:0] {ROW_ITEM, ROW_SIZE} row_kind_t;
    typedef enum logic [1:0] {FROM_MODEL, NO_SUM, SUM_IS} row_want_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_RES, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CFG_W-1:0]   size;
        logic               drain;
        logic [DATA_W-1:0]  value;
        row_want_t          want;
        logic [SUM_W-1:0]   sum;
        logic               last;
    } row_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             src_valid = 1'b0;
    logic             src_ready;
    in_item_t         src_item  = '0;
    logic             res_valid;
    logic             res_ready = 1'b0;
    out_item_t        res_item;

    int unsigned src_idle_pct  = 0;
    int unsigned res_stall_pct = 0;
    bit          hold_req      = 1'b0;
    bit          res_hold      = 1'b0;
    int unsigned mismatches    = 0;

    // predictor state
    logic [DATA_W-1:0] recent [WIN_LEN];
    logic [CFG_W-1:0]  side_reg;
    int unsigned       taken;
    int unsigned       emitted;
    out_item_t         due_sums [$];

    row_t script [0:29] = '{
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     NO_SUM,     18'd0, 1'b0},
        '{ROW_SIZE, 11'd1, ELEM,  16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     SUM_IS,     18'd0, 1'b1},
        '{ROW_SIZE, 11'd0, ELEM,  16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'd0,     NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'hFFFF,  SUM_IS,     18'd0, 1'b1},
        '{ROW_SIZE, 11'd2, ELEM,  16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'd1,     NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'd2,     NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'd4,     NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'd8,     SUM_IS,     18'd6, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  NO_SUM,     18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     SUM_IS,     18'd9, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     SUM_IS,     18'd9, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     SUM_IS,     18'd6, 1'b1},
        '{ROW_SIZE, 11'd3, ELEM,  16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, ELEM,  16'hFFFF,  FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     FROM_MODEL, 18'd0, 1'b0},
        '{ROW_ITEM, 11'd0, DRAIN, 16'd0,     FROM_MODEL, 18'd0, 1'b0}
    };

    four_neighbor_sum_stencil #(
        .MAX_SIZE (MAX_SIDE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    always #5 clk = ~clk;

    function automatic int unsigned side_eff();
        int unsigned s;
        s = 32'(side_reg);
        if (s == 0) s = 1;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    function automatic void set_side(input logic [CFG_W-1:0] v);
        side_reg = v;
        taken    = 0;
        emitted  = 0;
    endfunction

    function automatic void next_sum(output out_item_t r);
        int unsigned s;
        int unsigned total;
        int unsigned p;
        int unsigned acc;
        s     = side_eff();
        total = s * s;
        p     = emitted;
        acc   = 0;
        if (p >= s) acc += recent[(p - s) % WIN_LEN];
        if (p + s < total) acc += recent[(p + s) % WIN_LEN];
        if (p % s > 0) acc += recent[(p - 1) % WIN_LEN];
        if (p % s + 1 < s) acc += recent[(p + 1) % WIN_LEN];
        r.neighbor_sum   = acc[SUM_W-1:0];
        r.last_of_matrix = (p + 1 == total);
        emitted = p + 1;
        if (emitted >= total) begin
            emitted = 0;
            taken   = 0;
        end
    endfunction

    function automatic bit stencil_step(input in_item_t it, output out_item_t r);
        int unsigned s;
        int unsigned total;
        s     = side_eff();
        total = s * s;
        r     = '0;
        if (it.drain) begin
            if (taken >= total && emitted < total) begin
                next_sum(r);
                return 1'b1;
            end
            return 1'b0;
        end
        if (taken >= total) return 1'b0;
        recent[taken % WIN_LEN] = it.element_value;
        taken++;
        if (taken >= emitted + s + 2) begin
            next_sum(r);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // mostly well-formed matrices, with early drains and surplus elements as noise
    function automatic in_item_t pick_item();
        in_item_t    it;
        int unsigned total;
        total = side_eff() * side_eff();
        if ($urandom_range(0, 7) == 0)
            it.element_value = $urandom_range(0, 1) ? '1 : '0;
        else
            it.element_value = DATA_W'($urandom);
        if (taken < total)
            it.drain = ($urandom_range(0, 99) < 6);
        else
            it.drain = ($urandom_range(0, 99) < 92);
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 200)
            $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    task automatic send(input in_item_t it, output bit hit, output out_item_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_item  <= it;
        src_valid <= 1'b1;
        do @(posedge clk); while (!src_ready);
        hit = stencil_step(it, r);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] v);
        @(negedge clk);
        src_valid <= 1'b0;
        while (due_sums.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        set_side(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] side, input idle_mode_t mode,
                             input int n, input bit squeeze);
        in_item_t  it;
        out_item_t r;
        bit        hit;
        write_side(side);
        case (mode)
            IDLE_SRC:  begin src_idle_pct = 46; res_stall_pct = 0;  end
            IDLE_RES:  begin src_idle_pct = 0;  res_stall_pct = 46; end
            IDLE_BOTH: begin src_idle_pct = 35; res_stall_pct = 35; end
            default:   begin src_idle_pct = 0;  res_stall_pct = 0;  end
        endcase
        if (squeeze) hold_req = 1'b1;
        repeat (n) begin
            it = pick_item();
            send(it, hit, r);
            if (hit) due_sums.push_back(r);
        end
    endtask

    always @(negedge clk)
        res_ready <= !res_hold && ($urandom_range(0, 99) >= res_stall_pct);

    // long receiver hold so the result and command queues fill and src_ready drops
    initial begin
        forever begin
            wait (hold_req);
            @(posedge clk);
            res_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            res_hold = 1'b0;
            hold_req = 1'b0;
        end
    end

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && res_valid && res_ready) begin
            if (due_sums.size() == 0) begin
                report_mismatch("unexpected result, neighbor_sum",
                                int'(res_item.neighbor_sum), 0);
            end
            else begin
                want = due_sums.pop_front();
                if (res_item.neighbor_sum !== want.neighbor_sum)
                    report_mismatch("neighbor_sum", int'(res_item.neighbor_sum),
                                    int'(want.neighbor_sum));
                if (res_item.last_of_matrix !== want.last_of_matrix)
                    report_mismatch("last_of_matrix", int'(res_item.last_of_matrix),
                                    int'(want.last_of_matrix));
            end
        end
    end

    initial begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if ((src_valid && src_ready) || (res_valid && res_ready) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        in_item_t  it;
        out_item_t r;
        out_item_t w;
        bit        hit;
        foreach (recent[i]) recent[i] = '0;
        side_reg = 11'd8;
        taken    = 0;
        emitted  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < $size(script); i++) begin
            if (script[i].kind == ROW_SIZE) begin
                write_side(script[i].size);
            end
            else begin
                it.element_value = script[i].value;
                it.drain         = script[i].drain;
                send(it, hit, r);
                case (script[i].want)
                    FROM_MODEL: if (hit) due_sums.push_back(r);
                    SUM_IS: begin
                        w.neighbor_sum   = script[i].sum;
                        w.last_of_matrix = script[i].last;
                        due_sums.push_back(w);
                    end
                    default: ;
                endcase
            end
        end

        run_phase(11'd8,    IDLE_NONE, 100, 1'b0);
        run_phase(11'd3,    IDLE_SRC,  90,  1'b0);
        run_phase(11'd5,    IDLE_RES,  100, 1'b0);
        run_phase(11'd1,    IDLE_BOTH, 40,  1'b0);
        run_phase(11'd0,    IDLE_SRC,  30,  1'b0);
        run_phase(11'd4,    IDLE_NONE, 100, 1'b1);
        run_phase(11'd2,    IDLE_BOTH, 60,  1'b0);
        run_phase(11'd1024, IDLE_SRC,  40,  1'b0);
        run_phase(11'd7,    IDLE_RES,  80,  1'b0);
        run_phase(11'd2047, IDLE_BOTH, 40,  1'b0);
        run_phase(11'd16,   IDLE_BOTH, 150, 1'b0);
        run_phase(11'd6,    IDLE_NONE, 60,  1'b0);

        @(negedge clk);
        src_valid <= 1'b0;
        while (due_sums.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
